// ===== design/srsw_pkg.sv =====
// ============================================================================
// srsw_pkg: shared types and constants for the selective-repeat send window
// Item and result layouts, register indexes, the controller state encoding
// and the command/status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package srsw_pkg;

  // Flag store depth and sequence space limits
  localparam int MAX_SLOTS  = 16;
  localparam int MAX_SEQ    = 64;
  localparam int WIN_MIN    = 2;
  localparam int WIN_MAX    = 16;
  localparam int LEN_MIN    = 1;
  localparam int RNG_MIN    = 2;

  // Field widths
  localparam int SEQ_W      = 6;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 5;
  localparam int LEN_W      = 5;
  localparam int WIN_W      = 5;
  localparam int RNG_W      = SEQ_W + 1;
  localparam int DVD_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Register reset values
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(12);
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(7);
  localparam logic [RNG_W-1:0] RNG_RESET = RNG_W'(17);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_LENGTH = 2'd0,
    REG_WINDOW_SIZE   = 2'd1,
    REG_SEQ_RANGE     = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_SEND = 1'b0,
    OP_ACK  = 1'b1
  } op_t;

  typedef struct packed {
    logic             operation;
    logic [SEQ_W-1:0] ack_seq;
  } req_item_t;

  typedef struct packed {
    logic              status;
    logic [SEQ_W-1:0]  assigned_seq;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  slid_count;
    logic [SEQ_W-1:0]  new_base;
  } rsp_item_t;

  // Operand selection of the shared remainder unit
  typedef enum logic [2:0] {
    MOD_BASE = 3'd0,
    MOD_NEXT = 3'd1,
    MOD_END  = 3'd2,
    MOD_SLOT = 3'd3,
    MOD_RNG  = 3'd4,
    MOD_OFF  = 3'd5
  } mod_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_MOD_BASE = 4'd1,
    ST_MOD_NEXT = 4'd2,
    ST_MOD_END  = 4'd3,
    ST_DECIDE   = 4'd4,
    ST_MOD_SLOT = 4'd5,
    ST_MARK     = 4'd6,
    ST_MOD_RNG  = 4'd7,
    ST_MOD_OFF  = 4'd8,
    ST_SLIDE    = 4'd9,
    ST_FINISH   = 4'd10
  } ctrl_state_t;

  typedef struct packed {
    logic     load_item;
    logic     mod_run;
    mod_sel_t mod_sel;
    logic     send_commit;
    logic     mark;
    logic     slide_step;
    logic     result_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic op_ack;
    logic send_ok;
    logic ack_ok;
    logic at_base;
    logic slide_more;
    logic out_full;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/srsw_req_if.sv =====
// ============================================================================
// srsw_req_if: request channel
// Valid/ready channel carrying one send request or ack per transaction.
// ============================================================================
`default_nettype none

interface srsw_req_if;
  import srsw_pkg::*;

  logic      valid;
  logic      ready;
  req_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/srsw_rsp_if.sv =====
// ============================================================================
// srsw_rsp_if: result channel
// Valid/ready channel carrying one result per transaction.
// ============================================================================
`default_nettype none

interface srsw_rsp_if;
  import srsw_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/srsw_rem_unit.sv =====
// ============================================================================
// srsw_rem_unit: iterative remainder
// Restoring remainder, two dividend bits per cycle.
// ============================================================================
`default_nettype none

module srsw_rem_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [srsw_pkg::DVD_W-1:0]     dividend,
  input  wire logic [srsw_pkg::RNG_W-1:0]     divisor,
  output logic                                busy,
  output logic                                done,
  output logic [srsw_pkg::RNG_W-1:0]          result
);
  import srsw_pkg::*;

  logic [1:0]       cnt;
  logic [DVD_W-1:0] dvd;
  logic [RNG_W-1:0] rem;
  logic [RNG_W-1:0] dvs;

  logic [RNG_W:0]   t1, t2, s1, s2;
  logic [RNG_W-1:0] r1;

  // rem < divisor always, so one conditional subtract per bit suffices
  always_comb begin
    t1 = {rem, dvd[DVD_W-1]};
    s1 = (t1 >= {1'b0, dvs}) ? (t1 - {1'b0, dvs}) : t1;
    r1 = s1[RNG_W-1:0];
    t2 = {r1, dvd[DVD_W-2]};
    s2 = (t2 >= {1'b0, dvs}) ? (t2 - {1'b0, dvs}) : t2;
  end

  assign result = s2[RNG_W-1:0];
  assign done   = busy && (cnt == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 2'd0;
    end else if (busy) begin
      cnt <= cnt + 2'd1;
      if (cnt == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-3:0], 2'b00};
      rem <= s2[RNG_W-1:0];
    end
  end
endmodule

`default_nettype wire

// ===== design/srsw_ctrl.sv =====
// ============================================================================
// srsw_ctrl: sequencing state machine
// Steps one transaction through reduction, decision, marking and sliding.
// ============================================================================
`default_nettype none

module srsw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire srsw_pkg::dp_status_t st,
  output srsw_pkg::dp_cmd_t         cmd
);
  import srsw_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (req_valid) state_next = ST_MOD_BASE;
      ST_MOD_BASE: if (st.mod_done) state_next = ST_MOD_NEXT;
      ST_MOD_NEXT: if (st.mod_done) state_next = ST_MOD_END;
      ST_MOD_END:  if (st.mod_done) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (st.op_ack && st.ack_ok) state_next = ST_MOD_SLOT;
        else                        state_next = ST_FINISH;
      end
      ST_MOD_SLOT: if (st.mod_done) state_next = ST_MARK;
      ST_MARK: begin
        if (st.at_base) state_next = ST_MOD_RNG;
        else            state_next = ST_FINISH;
      end
      ST_MOD_RNG:  if (st.mod_done) state_next = ST_MOD_OFF;
      ST_MOD_OFF:  if (st.mod_done) state_next = ST_SLIDE;
      ST_SLIDE:    if (!st.slide_more) state_next = ST_FINISH;
      ST_FINISH:   if (!st.out_full) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready       = 1'b0;
    cmd             = '0;
    cmd.mod_sel     = MOD_BASE;
    unique case (state)
      ST_IDLE: begin
        req_ready     = 1'b1;
        cmd.load_item = req_valid;
      end
      ST_MOD_BASE: begin
        cmd.mod_run = 1'b1;
        cmd.mod_sel = MOD_BASE;
      end
      ST_MOD_NEXT: begin
        cmd.mod_run = 1'b1;
        cmd.mod_sel = MOD_NEXT;
      end
      ST_MOD_END: begin
        cmd.mod_run = 1'b1;
        cmd.mod_sel = MOD_END;
      end
      ST_DECIDE:   cmd.send_commit = !st.op_ack && st.send_ok;
      ST_MOD_SLOT: begin
        cmd.mod_run = 1'b1;
        cmd.mod_sel = MOD_SLOT;
      end
      ST_MARK:     cmd.mark = 1'b1;
      ST_MOD_RNG: begin
        cmd.mod_run = 1'b1;
        cmd.mod_sel = MOD_RNG;
      end
      ST_MOD_OFF: begin
        cmd.mod_run = 1'b1;
        cmd.mod_sel = MOD_OFF;
      end
      ST_SLIDE:    cmd.slide_step = st.slide_more;
      ST_FINISH:   cmd.result_load = !st.out_full;
      default:     cmd = '0;
    endcase
  end
endmodule

`default_nettype wire

// ===== design/srsw_datapath.sv =====
// ============================================================================
// srsw_datapath: window state, flag store and result register
// Holds configuration, window pointers, offsets and slot flags, and applies
// the commands of the controller.
// ============================================================================
`default_nettype none

module srsw_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [srsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srsw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire srsw_pkg::req_item_t              req_payload,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output srsw_pkg::rsp_item_t                   rsp_payload,
  input  wire srsw_pkg::dp_cmd_t                cmd,
  output srsw_pkg::dp_status_t                  st
);
  import srsw_pkg::*;

  // Configuration registers, raw as written
  logic [LEN_W-1:0] buffer_length;
  logic [WIN_W-1:0] window_size;
  logic [RNG_W-1:0] seq_range;

  // Window state
  logic [MAX_SLOTS-1:0] slot_flags;
  logic [SEQ_W-1:0]     window_base;
  logic [SEQ_W-1:0]     next_send_seq;
  logic [SLOT_W-1:0]    slot_offset;
  logic [SLOT_W-1:0]    prior_offset;

  // Per-transaction working registers
  logic              item_op;
  logic [SEQ_W-1:0]  item_seq;
  logic [SEQ_W-1:0]  win_end;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] rng_mod_len;
  logic [SLOT_W-1:0] off_red;
  logic [SLOT_W-1:0] slide_idx;
  logic [CNT_W-1:0]  slid;
  logic              res_status;
  logic [SEQ_W-1:0]  res_assigned;
  logic [SLOT_W-1:0] res_slot;

  logic [LEN_W-1:0] len;
  logic [WIN_W-1:0] win;
  logic [RNG_W-1:0] rng;

  logic [DVD_W-1:0] mod_dividend;
  logic [RNG_W-1:0] mod_divisor;
  logic             mod_busy;
  logic             mod_done;
  logic [RNG_W-1:0] mod_result;

  logic [SLOT_W-1:0] off_sel;
  logic [RNG_W-1:0]  next_p1, base_p1, end_p1;
  logic [SEQ_W-1:0]  next_inc, base_inc, end_inc;
  logic              end_wraps;
  logic [LEN_W-1:0]  off_sum;
  logic [SLOT_W-1:0] off_inc;
  logic [LEN_W-1:0]  idx_p1;
  logic [SLOT_W-1:0] idx_inc;

  function automatic logic in_window(input logic [SEQ_W-1:0] s,
                                     input logic [SEQ_W-1:0] b,
                                     input logic [SEQ_W-1:0] e);
    if (e > b)      return (s >= b) && (s <= e);
    else if (e < b) return (s >= b) || (s <= e);
    else            return 1'b0;
  endfunction

  // Saturate registers into their legal ranges
  always_comb begin
    if (buffer_length < LEN_W'(LEN_MIN))        len = LEN_W'(LEN_MIN);
    else if (buffer_length > LEN_W'(MAX_SLOTS)) len = LEN_W'(MAX_SLOTS);
    else                                        len = buffer_length;
    if (window_size < WIN_W'(WIN_MIN))          win = WIN_W'(WIN_MIN);
    else if (window_size > WIN_W'(WIN_MAX))     win = WIN_W'(WIN_MAX);
    else                                        win = window_size;
    if (seq_range < RNG_W'(RNG_MIN))            rng = RNG_W'(RNG_MIN);
    else if (seq_range > RNG_W'(MAX_SEQ))       rng = RNG_W'(MAX_SEQ);
    else                                        rng = seq_range;
  end

  // Upper part of a wrapped window uses the previous offset
  assign off_sel = ((win_end < window_base) && (item_seq >= window_base)) ?
                   prior_offset : slot_offset;

  always_comb begin
    mod_dividend = {2'b00, window_base};
    mod_divisor  = rng;
    unique case (cmd.mod_sel)
      MOD_BASE: mod_dividend = {2'b00, window_base};
      MOD_NEXT: mod_dividend = {2'b00, next_send_seq};
      MOD_END:  mod_dividend = {2'b00, window_base} + {3'b000, win} - DVD_W'(1);
      MOD_SLOT: begin
        mod_dividend = {2'b00, item_seq} + {4'b0000, off_sel};
        mod_divisor  = {2'b00, len};
      end
      MOD_RNG: begin
        mod_dividend = {1'b0, rng};
        mod_divisor  = {2'b00, len};
      end
      MOD_OFF: begin
        mod_dividend = {4'b0000, slot_offset};
        mod_divisor  = {2'b00, len};
      end
      default: begin
        mod_dividend = {2'b00, window_base};
        mod_divisor  = rng;
      end
    endcase
  end

  srsw_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_run && !mod_busy),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .busy     (mod_busy),
    .done     (mod_done),
    .result   (mod_result)
  );

  // Single-step wrap-around increments; operands already below their moduli
  always_comb begin
    next_p1   = {1'b0, next_send_seq} + RNG_W'(1);
    next_inc  = (next_p1 == rng) ? '0 : next_p1[SEQ_W-1:0];
    base_p1   = {1'b0, window_base} + RNG_W'(1);
    base_inc  = (base_p1 == rng) ? '0 : base_p1[SEQ_W-1:0];
    end_p1    = {1'b0, win_end} + RNG_W'(1);
    end_inc   = (end_p1 == rng) ? '0 : end_p1[SEQ_W-1:0];
    end_wraps = (end_inc < base_inc) && (win_end > window_base);
    off_sum   = {1'b0, off_red} + {1'b0, rng_mod_len};
    off_inc   = (off_sum >= len) ? SLOT_W'(off_sum - len) : off_sum[SLOT_W-1:0];
    idx_p1    = {1'b0, slide_idx} + LEN_W'(1);
    idx_inc   = (idx_p1 == len) ? '0 : idx_p1[SLOT_W-1:0];
  end

  always_comb begin
    st            = '0;
    st.mod_done   = mod_done;
    st.op_ack     = (item_op == OP_ACK);
    st.send_ok    = in_window(next_send_seq, window_base, win_end);
    st.ack_ok     = ({1'b0, item_seq} < rng) && in_window(item_seq, window_base, win_end);
    st.at_base    = (item_seq == window_base);
    st.slide_more = slot_flags[slide_idx] && (slid < len);
    st.out_full   = rsp_valid && !rsp_ready;
  end

  // Configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= LEN_RESET;
      window_size   <= WIN_RESET;
      seq_range     <= RNG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUFFER_LENGTH: buffer_length <= cfg_data[LEN_W-1:0];
        REG_WINDOW_SIZE:   window_size   <= cfg_data[WIN_W-1:0];
        REG_SEQ_RANGE:     seq_range     <= cfg_data[RNG_W-1:0];
        default:           ;
      endcase
    end
  end

  // Window state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_flags    <= '0;
      window_base   <= '0;
      next_send_seq <= '0;
      slot_offset   <= '0;
      prior_offset  <= '0;
    end else begin
      if (mod_done && cmd.mod_sel == MOD_BASE) window_base   <= mod_result[SEQ_W-1:0];
      if (mod_done && cmd.mod_sel == MOD_NEXT) next_send_seq <= mod_result[SEQ_W-1:0];
      if (cmd.send_commit) next_send_seq <= next_inc;
      if (cmd.mark) slot_flags[slot_q] <= 1'b1;
      if (cmd.slide_step) begin
        slot_flags[slide_idx] <= 1'b0;
        window_base           <= base_inc;
        if (end_wraps) begin
          prior_offset <= slot_offset;
          slot_offset  <= off_inc;
        end
      end
    end
  end

  // Working registers of the current transaction
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op      <= req_payload.operation;
      item_seq     <= req_payload.ack_seq;
      res_status   <= 1'b1;
      res_assigned <= '0;
      res_slot     <= '0;
      slid         <= '0;
    end
    if (mod_done) begin
      unique case (cmd.mod_sel)
        MOD_END:  win_end     <= mod_result[SEQ_W-1:0];
        MOD_SLOT: slot_q      <= mod_result[SLOT_W-1:0];
        MOD_RNG:  rng_mod_len <= mod_result[SLOT_W-1:0];
        MOD_OFF:  off_red     <= mod_result[SLOT_W-1:0];
        default:  ;
      endcase
    end
    if (cmd.send_commit) begin
      res_status   <= 1'b0;
      res_assigned <= next_send_seq;
    end
    if (cmd.mark) begin
      res_status <= 1'b0;
      res_slot   <= slot_q;
      slide_idx  <= slot_q;
    end
    if (cmd.slide_step) begin
      slid      <= slid + CNT_W'(1);
      slide_idx <= idx_inc;
      win_end   <= end_inc;
      if (end_wraps) off_red <= off_inc;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.result_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      rsp_payload.status       <= res_status;
      rsp_payload.assigned_seq <= res_assigned;
      rsp_payload.slot         <= res_slot;
      rsp_payload.slid_count   <= slid;
      rsp_payload.new_base     <= window_base;
    end
  end
endmodule

`default_nettype wire

// ===== design/selective_repeat_send_window.sv =====
// ============================================================================
// selective_repeat_send_window: sender side of a selective-repeat window
// Grants send requests inside the window, marks acked slots in a circular
// flag store and slides the base over consecutive acknowledged slots.
// ============================================================================
// Usage:
//   req carries one transaction per item: operation (send or ack) and the
//   ack sequence number. rsp returns exactly one result per request, in
//   order. cfg_we/cfg_index/cfg_data write buffer_length, window_size and
//   seq_range; write them only while no transaction is in flight.
// Sequencing:
//   One transaction at a time, each made of steps through the shared
//   remainder unit; a send or a rejected ack needs three of them. An ack
//   that is not at the base only marks its slot; an ack at the base also
//   slides the base over 1 to 16 consecutive acknowledged slots, with the
//   slide loop clearing one flag per cycle.
// Reset:
//   rst (synchronous) restores the registers to 12, 7 and 17, clears every
//   flag, zeroes base, next number and offsets, and empties rsp.
// Back-pressure:
//   The result sits in an output register; a new request is taken while it
//   waits. A finished transaction holds in its last step until the previous
//   result has been taken.
// ============================================================================
`default_nettype none

module selective_repeat_send_window (
  input  wire logic                            clk,
  input  wire logic                            rst,
  srsw_req_if.sink                             req,
  srsw_rsp_if.source                           rsp,
  input  wire logic                            cfg_we,
  input  wire logic [srsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srsw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import srsw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       req_ready;
  logic       rsp_valid;
  rsp_item_t  rsp_payload;

  // Sequence each transaction: reduce, decide, mark, slide, deliver
  srsw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Hold the window state and the result register
  srsw_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_payload (req.payload),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp_payload),
    .cmd         (cmd),
    .st          (st)
  );

  assign req.ready   = req_ready;
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_payload;
endmodule

`default_nettype wire

// ===== design/srsw_checker.sv =====
// ============================================================================
// srsw_checker: port-level checks for the send window
// Watches the channels of the top level over time; bound to it below.
// ============================================================================
`default_nettype none

module srsw_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic                          rsp_status,
  input wire logic [srsw_pkg::SEQ_W-1:0]    rsp_assigned_seq,
  input wire logic [srsw_pkg::SLOT_W-1:0]   rsp_slot,
  input wire logic [srsw_pkg::CNT_W-1:0]    rsp_slid_count
);
  import srsw_pkg::*;

  // A waiting result holds still
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({rsp_status, rsp_assigned_seq, rsp_slot, rsp_slid_count}))
    else $error("result changed while stalled");

  // A blocked send or rejected ack carries no number, slot or slide
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |->
      rsp_assigned_seq == '0 && rsp_slot == '0 && rsp_slid_count == '0)
    else $error("rejected result carries data");

  // Only an accepted ack slides the base
  a_slide_accepted: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_slid_count != '0 |-> !rsp_status)
    else $error("slide reported on a rejected item");

  // One transaction at a time: ready drops after an acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // Reset empties the result channel
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");
endmodule

bind selective_repeat_send_window srsw_checker u_srsw_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.payload.status),
  .rsp_assigned_seq (rsp.payload.assigned_seq),
  .rsp_slot         (rsp.payload.slot),
  .rsp_slid_count   (rsp.payload.slid_count)
);

`default_nettype wire
